// File: src/lfr_pkg.sv
// Shared constants for the literal find-and-replace stream block.
package lfr_pkg;

	// Width of the length registers and of the small byte counters.
	localparam int LEN_W = 4;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_TEXT     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_LENGTH   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_REPLACE_TEXT    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_REPLACE_LENGTH  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_CAPACITY = 3'd4;

	localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

endpackage

// File: src/literal_find_replace_stream.sv
// Top level of the streaming literal find-and-replace block.
//
// Copies a byte stream and replaces each leftmost, non-overlapping occurrence of the
// configured target with the replacement text. Bytes are held in a window as long as
// the target, so output lags input by up to target_length - 1 bytes. Each accepted item
// is decoded combinationally into a burst of output bytes (oldest window bytes or the
// replacement) plus an optional end report, and the burst drains through the output
// register at one beat per cycle while the output is not stalled. An item that yields
// zero or one result is taken every cycle unless the output stalls; a longer burst holds
// off the input until it drains, as there is a single output port. Bytes dropped after
// overflow still drain. Configuration must be written on the cfg channel only while the
// stream is idle; the block does not enforce this. The cfg channel is always ready.
module literal_find_replace_stream
	import lfr_pkg::*;
#(
	parameter int TARGET_MAX  = 8,
	parameter int REPLACE_MAX = 8,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]            cfg_data,

	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             data_byte,
	input  logic                   has_byte,
	input  logic                   end_mark,

	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             out_byte,
	output logic                   byte_valid,
	output logic                   last_result,
	output logic [15:0]            out_length,
	output logic                   overflow
);

	localparam int TW        = TARGET_MAX * 8;
	localparam int BURST_MAX = (TARGET_MAX > REPLACE_MAX) ? TARGET_MAX : REPLACE_MAX;
	localparam int BW        = BURST_MAX * 8;
	localparam int LW        = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

	// Configuration registers.
	logic [63:0]      target_text_q;
	logic [LEN_W-1:0] target_length_q;
	logic [63:0]      replace_text_q;
	logic [LEN_W-1:0] replace_length_q;
	logic [15:0]      output_capacity_q;

	// Stream state.
	logic [TW-1:0]          window_q;
	logic [LEN_W-1:0]       window_count_q;
	logic [COUNT_WIDTH-1:0] written_q;
	logic                   overflowed_q;

	// Pending burst.
	logic [BW-1:0]    burst_data_q;
	logic [LEN_W-1:0] burst_count_q;
	logic             report_q;

	// Output register.
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        byte_valid_q;
	logic        last_result_q;
	logic [15:0] out_length_q;
	logic        overflow_q;

	logic in_fire;
	logic cfg_fire;
	logic burst_busy;
	logic advance;
	logic last_beat;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;

	assign burst_busy = (burst_count_q != '0) | report_q;
	assign advance    = burst_busy & (~out_valid_q | out_ready);
	assign last_beat  = advance & (((burst_count_q == LEN_W'(1)) & ~report_q) |
		((burst_count_q == '0) & report_q));
	assign in_ready   = ~burst_busy | last_beat;
	assign in_fire    = in_valid & in_ready;

	// ---------------------------------------------------------------
	// Item decode: insert the byte, test for a match, plan the burst.
	// ---------------------------------------------------------------
	logic [LEN_W-1:0] tlen;
	logic [LEN_W-1:0] rlen;
	logic [LEN_W-1:0] keep;
	logic [LEN_W-1:0] cnt1;
	logic [LEN_W-1:0] pops;
	logic [TW-1:0]    win_ins;
	logic             match;
	logic             replace;

	always_comb begin
		tlen = (target_length_q > LEN_W'(TARGET_MAX)) ? LEN_W'(TARGET_MAX) : target_length_q;
		rlen = (replace_length_q > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX)
			: replace_length_q;
		keep = (tlen == '0) ? '0 : tlen - LEN_W'(1);
		cnt1 = window_count_q + LEN_W'(has_byte);

		for (int k = 0; k < TARGET_MAX; k++) begin
			win_ins[8*k +: 8] = (has_byte && window_count_q == LEN_W'(k)) ? data_byte
				: window_q[8*k +: 8];
		end

		match = 1'b1;
		for (int k = 0; k < TARGET_MAX; k++) begin
			if (LEN_W'(k) < tlen && win_ins[8*k +: 8] != target_text_q[8*k +: 8]) begin
				match = 1'b0;
			end
		end

		replace = 1'b0;
		pops    = '0;
		if (has_byte) begin
			if (tlen == '0 || cnt1 > tlen) begin
				// Pass-through, or the target was shortened: drain down to keep.
				pops = cnt1 - keep;
			end else if (cnt1 == tlen) begin
				if (match) begin
					replace = 1'b1;
				end else begin
					pops = LEN_W'(1);
				end
			end
		end
		if (end_mark && !replace) begin
			pops = cnt1;
		end
	end

	// ---------------------------------------------------------------
	// Drain side: capacity check for the byte at the head of the burst.
	// ---------------------------------------------------------------
	logic [15:0]   cap;
	logic [LW:0]   written_ext;
	logic          drop;

	always_comb begin
		cap         = (output_capacity_q == '0) ? 16'd1 : output_capacity_q;
		written_ext = (LW + 1)'(written_q);
		drop        = overflowed_q || (written_ext + (LW + 1)'(1) == (LW + 1)'(cap)) ||
			(written_q == '1);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_text_q     <= '0;
			target_length_q   <= '0;
			replace_text_q    <= '0;
			replace_length_q  <= '0;
			output_capacity_q <= CAPACITY_RESET;
			window_count_q    <= '0;
			written_q         <= '0;
			overflowed_q      <= 1'b0;
			burst_count_q     <= '0;
			report_q          <= 1'b0;
			out_valid_q       <= 1'b0;
		end else begin
			if (cfg_fire) begin
				unique case (cfg_index)
					CFG_TARGET_TEXT:     target_text_q     <= cfg_data;
					CFG_TARGET_LENGTH:   target_length_q   <= cfg_data[LEN_W-1:0];
					CFG_REPLACE_TEXT:    replace_text_q    <= cfg_data;
					CFG_REPLACE_LENGTH:  replace_length_q  <= cfg_data[LEN_W-1:0];
					CFG_OUTPUT_CAPACITY: output_capacity_q <= cfg_data[15:0];
					default: ;
				endcase
			end

			if (advance) begin
				if (burst_count_q != '0) begin
					burst_count_q <= burst_count_q - LEN_W'(1);
					out_valid_q   <= ~drop;
					if (drop) begin
						overflowed_q <= 1'b1;
					end else begin
						written_q <= written_q + COUNT_WIDTH'(1);
					end
				end else begin
					// End report closes the stream and clears the counters.
					report_q     <= 1'b0;
					out_valid_q  <= 1'b1;
					written_q    <= '0;
					overflowed_q <= 1'b0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (in_fire) begin
				burst_count_q  <= replace ? rlen : pops;
				report_q       <= end_mark;
				window_count_q <= replace ? '0 : cnt1 - pops;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			window_q     <= win_ins >> {pops, 3'b000};
			burst_data_q <= replace ? replace_text_q[BW-1:0] : BW'(win_ins);
		end else if (advance && burst_count_q != '0) begin
			burst_data_q <= burst_data_q >> 8;
		end

		if (advance) begin
			if (burst_count_q != '0) begin
				out_byte_q    <= burst_data_q[7:0];
				byte_valid_q  <= 1'b1;
				last_result_q <= 1'b0;
				out_length_q  <= '0;
				overflow_q    <= 1'b0;
			end else begin
				out_byte_q    <= '0;
				byte_valid_q  <= 1'b0;
				last_result_q <= 1'b1;
				out_length_q  <= overflowed_q ? '0 : 16'(written_q);
				overflow_q    <= overflowed_q;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign byte_valid  = byte_valid_q;
	assign last_result = last_result_q;
	assign out_length  = out_length_q;
	assign overflow    = overflow_q;

endmodule

// File: verif/tb.sv
// Self-checking testbench for the streaming literal find-and-replace block.
module tb;
	import lfr_pkg::*;

	localparam int WIN_DEPTH      = 8;
	localparam int SETTLE_CYCLES  = 24;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 24;

	typedef struct packed {
		logic [7:0]  data;
		logic        is_byte;
		logic        closes;
		logic [15:0] length;
		logic        ovf;
	} out_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [63:0]            cfg_data = '0;

	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = '0;
	logic       has_byte = 1'b0;
	logic       end_mark = 1'b0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        last_result;
	logic [15:0] out_length;
	logic        overflow;

	always #1 clk = ~clk;

	literal_find_replace_stream u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.has_byte    (has_byte),
		.end_mark    (end_mark),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.last_result (last_result),
		.out_length  (out_length),
		.overflow    (overflow)
	);

	// Register copies and stream state of the predictor.
	logic [63:0] tgt_text = '0;
	logic [3:0]  tgt_len = '0;
	logic [63:0] rep_text = '0;
	logic [3:0]  rep_len = '0;
	logic [15:0] capacity = CAPACITY_RESET;

	logic [7:0]  win [WIN_DEPTH];
	int unsigned win_cnt = 0;
	int unsigned written = 0;
	bit          overflowed = 1'b0;

	out_beat_t   due_beats [$];
	int unsigned fail_count = 0;

	bit          idle_enable = 1'b1;
	int unsigned burst_left = 0;

	function automatic void push_beat(logic [7:0] b, logic v, logic l, logic [15:0] len,
			logic o);
		out_beat_t beat;
		beat = {b, v, l, len, o};
		due_beats.push_back(beat);
	endfunction

	function automatic void write_dest(logic [7:0] b);
		int unsigned room;
		room = (capacity == 16'd0) ? 1 : capacity;
		if (overflowed)
			return;
		if (written + 1 == room || written >= 32'hFFFF) begin
			overflowed = 1'b1;
			return;
		end
		written++;
		push_beat(b, 1'b1, 1'b0, 16'd0, 1'b0);
	endfunction

	function automatic void shift_out_oldest();
		logic [7:0] b;
		b = win[0];
		for (int k = 1; k < WIN_DEPTH; k++)
			win[k-1] = win[k];
		win_cnt--;
		write_dest(b);
	endfunction

	function automatic bit window_is_target(int unsigned n);
		for (int unsigned k = 0; k < n; k++)
			if (win[k] != tgt_text[8*k +: 8])
				return 1'b0;
		return 1'b1;
	endfunction

	// Works out the destination beats caused by one accepted input beat.
	function automatic void predict_rewrite(logic [7:0] b, logic h, logic e);
		int unsigned tl;
		int unsigned rl;
		int unsigned keep;
		if (!h && !e)
			return;
		tl = (tgt_len > WIN_DEPTH) ? WIN_DEPTH : tgt_len;
		rl = (rep_len > WIN_DEPTH) ? WIN_DEPTH : rep_len;
		if (h) begin
			if (win_cnt >= WIN_DEPTH)
				shift_out_oldest();
			win[win_cnt] = b;
			win_cnt++;
			if (tl == 0 || win_cnt > tl) begin
				// A shortened target leaves extra bytes that go out unmatched.
				keep = (tl == 0) ? 0 : tl - 1;
				while (win_cnt > keep)
					shift_out_oldest();
			end else if (win_cnt == tl) begin
				if (window_is_target(tl)) begin
					win_cnt = 0;
					for (int unsigned k = 0; k < rl; k++)
						write_dest(rep_text[8*k +: 8]);
				end else begin
					shift_out_oldest();
				end
			end
		end
		if (e) begin
			while (win_cnt > 0)
				shift_out_oldest();
			push_beat(8'd0, 1'b0, 1'b1, overflowed ? 16'd0 : 16'(written), overflowed);
			win_cnt = 0;
			written = 0;
			overflowed = 1'b0;
		end
	endfunction

	function automatic void store_setting(logic [CFG_INDEX_W-1:0] idx, logic [63:0] val);
		case (idx)
			CFG_TARGET_TEXT:     tgt_text = val;
			CFG_TARGET_LENGTH:   tgt_len = val[3:0];
			CFG_REPLACE_TEXT:    rep_text = val;
			CFG_REPLACE_LENGTH:  rep_len = val[3:0];
			CFG_OUTPUT_CAPACITY: capacity = val[15:0];
			default: ;
		endcase
	endfunction

	task automatic send_item(logic [7:0] b, logic h, logic e);
		int unsigned gap;
		in_valid  <= 1'b1;
		data_byte <= b;
		has_byte  <= h;
		end_mark  <= e;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_rewrite(b, h, e);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = idle_enable ? $urandom_range(0, 15) : 0;
			gap = idle_enable ? $urandom_range(1, 5) : 0;
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_text(string s, bit end_on_last);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b1, end_on_last && i == s.len() - 1);
	endtask

	// Drain every expected beat, then allow for dropped bytes still in flight.
	task automatic idle_wait();
		in_valid <= 1'b0;
		while (due_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		store_setting(idx, val);
	endtask

	task automatic write_settings(logic [63:0] tt, logic [63:0] tl, logic [63:0] rt,
			logic [63:0] rl, logic [63:0] cap);
		write_reg(CFG_TARGET_TEXT, tt);
		write_reg(CFG_TARGET_LENGTH, tl);
		write_reg(CFG_REPLACE_TEXT, rt);
		write_reg(CFG_REPLACE_LENGTH, rl);
		write_reg(CFG_OUTPUT_CAPACITY, cap);
		cfg_valid <= 1'b0;
	endtask

	function automatic void flag_beat(string why, out_beat_t want, out_beat_t got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s: expected byte %02h valid %0b last %0b len %0d ovf %0b",
				why, want.data, want.is_byte, want.closes, want.length, want.ovf);
			$display("%s: got byte %02h valid %0b last %0b len %0d ovf %0b",
				why, got.data, got.is_byte, got.closes, got.length, got.ovf);
		end
	endfunction

	out_beat_t seen_beat;
	out_beat_t want_beat;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_beat = {out_byte, byte_valid, last_result, out_length, overflow};
			if (due_beats.size() == 0) begin
				flag_beat("unexpected beat", '0, seen_beat);
			end else begin
				want_beat = due_beats.pop_front();
				if (seen_beat !== want_beat)
					flag_beat("mismatch", want_beat, seen_beat);
			end
		end
	end

	// The receiver follows a rotating stall pattern that changes now and then.
	logic [15:0] ready_pattern = 16'hFFFF;
	int unsigned pattern_pos = 0;
	int unsigned pattern_age = 0;

	always @(posedge clk) begin
		out_ready <= ready_pattern[pattern_pos];
		pattern_pos = (pattern_pos + 1) % 16;
		pattern_age++;
		if (pattern_age == 80) begin
			pattern_age = 0;
			ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
		end
	end

	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Reset values give pass-through; an item with neither byte nor end is ignored.
	task automatic test_passthrough_defaults();
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h5A, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
	endtask

	task automatic test_match_replace();
		idle_wait();
		write_settings(64'h6261, 64'd2, 64'h5A5958, 64'd3, 64'hFFFF);
		send_text("aabab", 1'b1);
	endtask

	// Lengths above eight saturate; the stream closes with an end beat that carries no byte.
	task automatic test_length_saturation();
		idle_wait();
		write_settings(64'hFFEE_DDCC_BBAA_9988, 64'd15, 64'h00FF_00FF_00FF_00FF, 64'd15,
			64'hFFFF);
		for (int k = 0; k < 8; k++)
			send_item(8'h88 + 8'(k * 17), 1'b1, 1'b0);
		send_item(8'h3C, 1'b0, 1'b1);
	endtask

	task automatic test_capacity_overflow();
		idle_wait();
		write_settings(64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
		send_item(8'h11, 1'b1, 1'b1);
		idle_wait();
		write_settings(64'd0, 64'd0, 64'd0, 64'd0, 64'd3);
		send_text("abc", 1'b1);
	endtask

	// The target gets shorter, then disabled, while bytes still wait in the window.
	task automatic test_target_shortened();
		idle_wait();
		write_settings(64'h7A797877, 64'd4, 64'h51, 64'd1, 64'hFFFF);
		send_text("wxy", 1'b0);
		idle_wait();
		write_settings(64'h7A797877, 64'd2, 64'h51, 64'd1, 64'hFFFF);
		send_item("x", 1'b1, 1'b0);
		idle_wait();
		write_settings(64'h7A797877, 64'd0, 64'h51, 64'd1, 64'hFFFF);
		send_item("z", 1'b1, 1'b1);
	endtask

	// Streams are built mostly from whole and partial copies of the target.
	task automatic run_random_phase(int unsigned quota);
		logic [7:0]  src [$];
		logic [63:0] tt;
		logic [63:0] rt;
		logic [3:0]  tl;
		logic [3:0]  rl;
		logic [15:0] cp;
		int unsigned done;
		int unsigned tl_eff;
		int unsigned part;
		bit          end_on_byte;
		tt = {$urandom, $urandom};
		rt = {$urandom, $urandom};
		tl = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
		rl = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
		case ($urandom_range(0, 4))
			0: cp = 16'($urandom_range(0, 12));
			1: cp = 16'hFFFF;
			default: cp = 16'($urandom_range(13, 65534));
		endcase
		idle_wait();
		write_settings(tt, 64'(tl), rt, 64'(rl), 64'(cp));
		idle_enable = ($urandom_range(0, 3) != 0);
		tl_eff = (tl > WIN_DEPTH) ? WIN_DEPTH : tl;
		done = 0;
		while (done < quota) begin
			src.delete();
			repeat ($urandom_range(0, 8)) begin
				case ($urandom_range(0, 3))
					0: for (int unsigned k = 0; k < tl_eff; k++)
						src.push_back(tt[8*k +: 8]);
					1: if (tl_eff > 1) begin
						part = $urandom_range(1, tl_eff - 1);
						for (int unsigned k = 0; k < part; k++)
							src.push_back(tt[8*k +: 8]);
					end
					2: src.push_back(tt[8*$urandom_range(0, 7) +: 8]);
					default: src.push_back(8'($urandom));
				endcase
			end
			end_on_byte = (src.size() != 0) && ($urandom_range(0, 1) == 1);
			foreach (src[i]) begin
				if ($urandom_range(0, 15) == 0)
					send_item(8'($urandom), 1'b0, 1'b0);
				send_item(src[i], 1'b1, end_on_byte && i == src.size() - 1);
			end
			if (!end_on_byte)
				send_item(8'($urandom), 1'b0, 1'b1);
			done += src.size() + (end_on_byte ? 0 : 1);
		end
	endtask

	task automatic test_random_streams();
		repeat (6) run_random_phase(ITEMS_PER_PHASE);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_passthrough_defaults();
		test_match_replace();
		test_length_saturation();
		test_capacity_overflow();
		test_target_shortened();
		test_random_streams();
		idle_wait();
		if (fail_count == 0 && due_beats.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: literal_find_replace_stream.f
src/lfr_pkg.sv
src/literal_find_replace_stream.sv
verif/tb.sv
